// File: rtl/led_column_gamma_dither_core_assert.svh
// led_column_gamma_dither_core_assert.svh: assertion macros for the LED column core.
// Needs signals named clk and arst_n in the including scope.
`ifndef LED_COLUMN_GAMMA_DITHER_CORE_ASSERT_SVH
`define LED_COLUMN_GAMMA_DITHER_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define LCGD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define LCGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lcgd_pkg.sv
`timescale 1ns / 1ps
// lcgd_pkg: constants, codes and beat/struct types of the LED column gamma dither core.
// No dependencies; used by lcgd_chan and led_column_gamma_dither_core.
package lcgd_pkg;

	localparam int ROWS   = 1024;
	localparam int ERR_AW = $clog2(ROWS);
	localparam logic [10:0]       ROW_LIMIT  = 11'(ROWS);
	localparam logic [ERR_AW-1:0] SWEEP_LAST = ERR_AW'(ROWS - 1);

	localparam logic [1:0] KIND_PIX = 2'd0;
	localparam logic [1:0] KIND_TBL = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;

	localparam logic [1:0] REG_RED   = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_BLUE  = 2'd2;

	localparam logic [3:0] SEL_LOW  = 4'd0;
	localparam logic [3:0] SEL_HIGH = 4'd3;
	localparam logic [3:0] SEL_FRAC = 4'd6;
	localparam logic [3:0] SEL_LAST = 4'd8;

	localparam logic [7:0] HEADER     = 8'hFF;
	localparam logic [8:0] WEIGHT_MIN = 9'd1;
	localparam logic [8:0] WEIGHT_MAX = 9'd256;
	localparam logic [8:0] WEIGHT_SUM = 9'd257;

	// Input beat, pad in the top bits and row in the bottom bits
	typedef struct packed {
		logic       pad;
		logic [7:0] table_value;
		logic [7:0] table_index;
		logic [3:0] table_select;
		logic [8:0] right_weight;
		logic [7:0] right_blue;
		logic [7:0] right_green;
		logic [7:0] right_red;
		logic [7:0] left_blue;
		logic [7:0] left_green;
		logic [7:0] left_red;
		logic [9:0] row;
	} in_beat_t;

	localparam int IN_W = $bits(in_beat_t);

	typedef struct packed {
		logic       lo_we;
		logic       hi_we;
		logic       fr_we;
		logic [7:0] idx;
		logic [7:0] val;
	} tbl_wr_t;

	typedef struct packed {
		logic              pix;
		logic [ERR_AW-1:0] row;
	} err_wb_t;

	typedef struct packed {
		logic              active;
		logic [ERR_AW-1:0] addr;
	} sweep_t;

endpackage

// File: rtl/lcgd_chan.sv
`timescale 1ns / 1ps
// lcgd_chan: one color channel: blend multiply, level/fraction tables, error store.
// Depends on lcgd_pkg.
module lcgd_chan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [7:0]                    left_px,
	input  logic [7:0]                    right_px,
	input  logic [8:0]                    left_wt,
	input  logic [8:0]                    right_wt,
	input  lcgd_pkg::tbl_wr_t             tbl_wr,
	input  logic [lcgd_pkg::ERR_AW-1:0]   rd_row,
	input  lcgd_pkg::err_wb_t             err_wb,
	input  lcgd_pkg::sweep_t              sweep,
	output logic [7:0]                    level
);
	import lcgd_pkg::*;

	logic [7:0] low_mem  [256];
	logic [7:0] high_mem [256];
	logic [7:0] frac_mem [256];
	logic [7:0] err_mem  [ROWS];

	logic [16:0] pl_s2;
	logic [16:0] pr_s2;
	logic [16:0] sum;
	logic [7:0]  n_s3;
	logic [7:0]  lo_s4;
	logic [7:0]  hi_s4;
	logic [7:0]  fr_s4;
	logic [7:0]  er_s4;

	logic              fwd_vld_q;
	logic [ERR_AW-1:0] fwd_row_q;
	logic [7:0]        fwd_val_q;
	logic [7:0]        err_cur;
	logic [8:0]        acc;

	// Stage 2: products, stage 3: blended level
	assign sum = pl_s2 + pr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s2 <= {9'd0, left_px} * {8'd0, left_wt};
			pr_s2 <= {9'd0, right_px} * {8'd0, right_wt};
			n_s3  <= sum[15:8];
		end
	end

	// Tables: written and read in stage 3, read data lands in stage 4
	always_ff @(posedge clk) begin
		if (adv) begin
			if (tbl_wr.lo_we) begin
				low_mem[tbl_wr.idx] <= tbl_wr.val;
			end
			if (tbl_wr.hi_we) begin
				high_mem[tbl_wr.idx] <= tbl_wr.val;
			end
			if (tbl_wr.fr_we) begin
				frac_mem[tbl_wr.idx] <= tbl_wr.val;
			end
			lo_s4 <= low_mem[n_s3];
			hi_s4 <= high_mem[n_s3];
			fr_s4 <= frac_mem[n_s3];
		end
	end

	// Error store: read in stage 3, written back from stage 4, zeroed by the sweep
	always_ff @(posedge clk) begin
		if (sweep.active) begin
			err_mem[sweep.addr] <= '0;
		end else if (adv && err_wb.pix) begin
			err_mem[err_wb.row] <= acc[7:0];
		end
		if (adv) begin
			er_s4 <= err_mem[rd_row];
		end
	end

	// The write of the item just ahead lands on the same edge as this read: bypass it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (sweep.active) begin
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			fwd_vld_q <= err_wb.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_row_q <= err_wb.row;
			fwd_val_q <= acc[7:0];
		end
	end

	assign err_cur = (fwd_vld_q && fwd_row_q == err_wb.row) ? fwd_val_q : er_s4;
	assign acc     = {1'b0, fr_s4} + {1'b0, err_cur};
	assign level   = acc[8] ? hi_s4 : lo_s4;

endmodule

// File: rtl/led_column_gamma_dither_core.sv
`timescale 1ns / 1ps
// LED column gamma dither core: blends two source pixels per LED row, applies
// gamma tables with temporal error diffusion, and builds a 4-byte LED word.
// Input beats arrive on s_axis (tuser = kind), LED words leave on m_axis.
// A pixel beat (kind 0) yields one LED word; a table write (kind 1), a clear
// (kind 2) and kind 3 yield none. Rows at or above the row count are dropped.
// A pixel beat passes stages 1 to 4 and shows on m_axis from the stage-5 register.
// Throughput: one beat per cycle unless a stall or a sweep holds input off; the pipeline has five
// register stages and the error store is a one-port-write memory per channel read in stage 3.
// Slot registers on the APB port (0x0 red, 0x4 green, 0x8 blue) are to be written by the user
// while the core is idle; the core itself does not enforce this. pready is always high.
// Reset and clear: after reset, and after a clear beat reaches stage 4, a sweep
// zeroes the 1024-entry error store one row per cycle; s_axis_tready
// is low from the clear beat's acceptance, or from reset, until the sweep ends.
// Tables are not cleared and must be loaded before pixel beats.
// Stall: when m_axis_tready is low with a word pending, every stage holds and
// s_axis_tready drops; nothing is lost or repeated.
`include "led_column_gamma_dither_core_assert.svh"
module led_column_gamma_dither_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// row, left_red, left_green, left_blue, right_red, right_green, right_blue,
	// right_weight, table_select, table_index, table_value, zero pad
	input  logic [lcgd_pkg::IN_W-1:0]   s_axis_tdata,
	// kind
	input  logic [1:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// header_byte, slot_one, slot_two, slot_three
	output logic [31:0]                 m_axis_tdata
);
	import lcgd_pkg::*;

	logic [1:0] reg_idx;
	logic       cfg_we;
	logic [1:0] red_slot_q;
	logic [1:0] green_slot_q;
	logic [1:0] blue_slot_q;

	in_beat_t beat;
	logic     accept;
	logic     adv;

	logic pix_s1, tbl_s1, clr_s1;
	logic pix_s2, tbl_s2, clr_s2;
	logic pix_s3, tbl_s3, clr_s3;
	logic pix_s4, clr_s4;
	logic vld_s5;

	logic [ERR_AW-1:0] row_s1, row_s2, row_s3, row_s4;
	logic [3:0]        sel_s1, sel_s2, sel_s3;
	logic [7:0]        idx_s1, idx_s2, idx_s3;
	logic [7:0]        val_s1, val_s2, val_s3;
	logic [7:0]        left_s1  [3];
	logic [7:0]        right_s1 [3];
	logic [8:0]        weight_s1;
	logic [8:0]        rw;
	logic [8:0]        lw;

	logic              block_q;
	logic              sweep_q;
	logic [ERR_AW-1:0] sweep_cnt_q;

	tbl_wr_t       tw [3];
	logic [7:0]    lvl [3];
	logic [3:0][7:0] word;
	logic [31:0]   word_s5;

	// Configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_slot_q   <= 2'd2;
			green_slot_q <= 2'd3;
			blue_slot_q  <= 2'd1;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_RED:   red_slot_q   <= pwdata[1:0];
				REG_GREEN: green_slot_q <= pwdata[1:0];
				REG_BLUE:  blue_slot_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RED:   prdata = {30'd0, red_slot_q};
			REG_GREEN: prdata = {30'd0, green_slot_q};
			REG_BLUE:  prdata = {30'd0, blue_slot_q};
			default:   prdata = '0;
		endcase
	end

	// Handshake: all stages move together when the output register frees up
	assign beat          = in_beat_t'(s_axis_tdata);
	assign adv           = !vld_s5 || m_axis_tready;
	assign s_axis_tready = adv && !block_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Stage flags carry validity and kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0; tbl_s1 <= 1'b0; clr_s1 <= 1'b0;
			pix_s2 <= 1'b0; tbl_s2 <= 1'b0; clr_s2 <= 1'b0;
			pix_s3 <= 1'b0; tbl_s3 <= 1'b0; clr_s3 <= 1'b0;
			pix_s4 <= 1'b0; clr_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			pix_s1 <= accept && s_axis_tuser == KIND_PIX && {1'b0, beat.row} < ROW_LIMIT;
			tbl_s1 <= accept && s_axis_tuser == KIND_TBL && beat.table_select <= SEL_LAST;
			clr_s1 <= accept && s_axis_tuser == KIND_CLR;
			pix_s2 <= pix_s1; tbl_s2 <= tbl_s1; clr_s2 <= clr_s1;
			pix_s3 <= pix_s2; tbl_s3 <= tbl_s2; clr_s3 <= clr_s2;
			pix_s4 <= pix_s3; clr_s4 <= clr_s3;
			vld_s5 <= pix_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1      <= beat.row[ERR_AW-1:0];
			sel_s1      <= beat.table_select;
			idx_s1      <= beat.table_index;
			val_s1      <= beat.table_value;
			weight_s1   <= beat.right_weight;
			left_s1[0]  <= beat.left_red;
			left_s1[1]  <= beat.left_green;
			left_s1[2]  <= beat.left_blue;
			right_s1[0] <= beat.right_red;
			right_s1[1] <= beat.right_green;
			right_s1[2] <= beat.right_blue;
			row_s2 <= row_s1; sel_s2 <= sel_s1; idx_s2 <= idx_s1; val_s2 <= val_s1;
			row_s3 <= row_s2; sel_s3 <= sel_s2; idx_s3 <= idx_s2; val_s3 <= val_s2;
			row_s4 <= row_s3;
			word_s5 <= word;
		end
	end

	// Weight: zero acts as one, anything above 256 as 256
	always_comb begin
		if (weight_s1 < WEIGHT_MIN) begin
			rw = WEIGHT_MIN;
		end else if (weight_s1 > WEIGHT_MAX) begin
			rw = WEIGHT_MAX;
		end else begin
			rw = weight_s1;
		end
		lw = WEIGHT_SUM - rw;
	end

	// Error store sweep after reset and after a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q     <= 1'b1;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else begin
			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				if (sweep_cnt_q == SWEEP_LAST) begin
					sweep_q <= 1'b0;
					block_q <= 1'b0;
				end
			end else if (adv && clr_s4) begin
				sweep_q     <= 1'b1;
				sweep_cnt_q <= '0;
			end
			// hold off input from the clear beat on
			if (accept && s_axis_tuser == KIND_CLR) begin
				block_q <= 1'b1;
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		always_comb begin
			tw[c].lo_we = tbl_s3 && sel_s3 == SEL_LOW + 4'(c);
			tw[c].hi_we = tbl_s3 && sel_s3 == SEL_HIGH + 4'(c);
			tw[c].fr_we = tbl_s3 && sel_s3 == SEL_FRAC + 4'(c);
			tw[c].idx   = idx_s3;
			tw[c].val   = val_s3;
		end

		lcgd_chan u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.left_px  (left_s1[c]),
			.right_px (right_s1[c]),
			.left_wt  (lw),
			.right_wt (rw),
			.tbl_wr   (tw[c]),
			.rd_row   (row_s3),
			.err_wb   (err_wb_t'{pix: pix_s4, row: row_s4}),
			.sweep    (sweep_t'{active: sweep_q, addr: sweep_cnt_q}),
			.level    (lvl[c])
		);
	end

	// Slot mapping: red, then green, then blue, so the later channel wins
	always_comb begin
		logic [1:0] slot [3];
		slot[0] = red_slot_q;
		slot[1] = green_slot_q;
		slot[2] = blue_slot_q;
		word    = '0;
		for (int c = 0; c < 3; c++) begin
			if (slot[c] != 2'd0) begin
				word[slot[c]] = lvl[c];
			end
		end
		word[0] = HEADER;
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = word_s5;

	`LCGD_ASSERT_SAME(a_sweep_no_accept, sweep_q, !s_axis_tready, "beat accepted during error sweep")
	`LCGD_ASSERT_SAME(a_sweep_s4_empty, sweep_q, !pix_s4 && !clr_s4, "stage 4 busy during error sweep")
	`LCGD_ASSERT_NEXT(a_sweep_release, sweep_q && sweep_cnt_q == SWEEP_LAST, !sweep_q && !block_q, "input not released after error sweep")

endmodule
